[hdl/ade_pkg.sv]
// Shared types, operation codes and helpers of the data-processing execute block.
`timescale 1ns / 1ps

package ade_pkg;

    // Stream widths: tdata is padded to whole bytes.
    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 40;

    localparam int WORD_W = 32;

    // NZCV bit positions.
    localparam int FL_N = 3;
    localparam int FL_Z = 2;
    localparam int FL_C = 1;
    localparam int FL_V = 0;

    localparam logic [31:0] MASK_LO16 = 32'h0000_FFFF;

    typedef enum logic [4:0] {
        FN_AND   = 5'd0,
        FN_ORR   = 5'd1,
        FN_BIC   = 5'd2,
        FN_TST   = 5'd3,
        FN_CMP   = 5'd4,
        FN_CMN   = 5'd5,
        FN_RSB   = 5'd6,
        FN_MOV   = 5'd7,
        FN_MVN   = 5'd8,
        FN_MOVW  = 5'd9,
        FN_MOVT  = 5'd10,
        FN_REV   = 5'd11,
        FN_REV16 = 5'd12,
        FN_REVSH = 5'd13,
        FN_UXTB  = 5'd14,
        FN_UXTH  = 5'd15,
        FN_SXTB  = 5'd16,
        FN_SXTH  = 5'd17
    } func_t;

    // Condition pairs: cond[3:1]; cond[0] inverts the test, except for the always pair.
    localparam logic [2:0] CP_EQNE = 3'd0;
    localparam logic [2:0] CP_CSCC = 3'd1;
    localparam logic [2:0] CP_MIPL = 3'd2;
    localparam logic [2:0] CP_VSVC = 3'd3;
    localparam logic [2:0] CP_HILS = 3'd4;
    localparam logic [2:0] CP_GELT = 3'd5;
    localparam logic [2:0] CP_GTLE = 3'd6;
    localparam logic [2:0] CP_ALWAYS = 3'd7;

    // Operation controls held in the first pipeline stage.
    typedef struct packed {
        func_t func;
        logic  cond_ok;
        logic  set_flags;
        logic  shifter_carry;
        logic  dest_is_pc;
    } op_ctrl_t;

    // Destination and flag-update controls produced by the ALU stage.
    typedef struct packed {
        logic executed;
        logic reg_write;
        logic pc_write;
        logic exc_return;
        logic wr_nz;
        logic wr_c;
        logic c_val;
        logic wr_v;
        logic v_val;
    } res_ctrl_t;

    function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
        logic r;
        logic pass;
        r = 1'b0;
        pass = 1'b1;
        case (c[3:1])
            CP_EQNE:   r = f[FL_Z];
            CP_CSCC:   r = f[FL_C];
            CP_MIPL:   r = f[FL_N];
            CP_VSVC:   r = f[FL_V];
            CP_HILS:   r = f[FL_C] & ~f[FL_Z];
            CP_GELT:   r = (f[FL_N] == f[FL_V]);
            CP_GTLE:   r = ~f[FL_Z] & (f[FL_N] == f[FL_V]);
            CP_ALWAYS: r = 1'b1;
            default:   r = 1'b1;
        endcase
        if (c[3:1] == CP_ALWAYS)
        begin
            pass = 1'b1;
        end
        else
        begin
            pass = c[0] ? ~r : r;
        end
        return pass;
    endfunction

endpackage

[hdl/ade_alu.sv]
// Result selection, adder and destination/flag decisions for one operation.
`timescale 1ns / 1ps

module ade_alu (
    input  ade_pkg::op_ctrl_t  ctrl,
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    input  logic [31:0]        dest_old,
    input  logic [31:0]        add_x,
    input  logic [31:0]        add_y,
    input  logic               add_cin,
    output ade_pkg::res_ctrl_t rctl,
    output logic [31:0]        result
);

    logic [32:0] sum;
    logic        add_c;
    logic        add_v;
    logic [31:0] b;
    logic        is_byte;
    logic        is_dp;
    logic        logical;
    logic        to_dest;
    logic        movwt;
    logic        flag_arith;
    logic [31:0] res_raw;

    assign b     = operand_b;
    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_c = sum[32];
    assign add_v = (add_x[31] == add_y[31]) && (sum[31] != add_x[31]);

    always_comb
    begin
        res_raw    = '0;
        is_byte    = 1'b0;
        is_dp      = 1'b1;
        logical    = 1'b0;
        to_dest    = 1'b1;
        movwt      = 1'b0;
        flag_arith = 1'b0;
        case (ctrl.func)
            ade_pkg::FN_AND:
            begin
                res_raw = operand_a & b;
                logical = 1'b1;
            end
            ade_pkg::FN_ORR:
            begin
                res_raw = operand_a | b;
                logical = 1'b1;
            end
            ade_pkg::FN_BIC:
            begin
                res_raw = operand_a & ~b;
                logical = 1'b1;
            end
            ade_pkg::FN_TST:
            begin
                res_raw = operand_a & b;
                to_dest = 1'b0;
            end
            ade_pkg::FN_CMP, ade_pkg::FN_CMN:
            begin
                res_raw    = sum[31:0];
                to_dest    = 1'b0;
                flag_arith = 1'b1;
            end
            ade_pkg::FN_RSB:
            begin
                res_raw = sum[31:0];
            end
            ade_pkg::FN_MOV:
            begin
                res_raw = b;
                logical = 1'b1;
            end
            ade_pkg::FN_MVN:
            begin
                res_raw = ~b;
                logical = 1'b1;
            end
            ade_pkg::FN_MOVW:
            begin
                res_raw = b & ade_pkg::MASK_LO16;
                movwt   = 1'b1;
            end
            ade_pkg::FN_MOVT:
            begin
                res_raw = {b[15:0], dest_old[15:0]};
                movwt   = 1'b1;
            end
            ade_pkg::FN_REV:
            begin
                res_raw = {b[7:0], b[15:8], b[23:16], b[31:24]};
                is_byte = 1'b1;
            end
            ade_pkg::FN_REV16:
            begin
                res_raw = {b[23:16], b[31:24], b[7:0], b[15:8]};
                is_byte = 1'b1;
            end
            ade_pkg::FN_REVSH:
            begin
                res_raw = {{16{b[7]}}, b[7:0], b[15:8]};
                is_byte = 1'b1;
            end
            ade_pkg::FN_UXTB:
            begin
                res_raw = {24'd0, b[7:0]};
                is_byte = 1'b1;
            end
            ade_pkg::FN_UXTH:
            begin
                res_raw = {16'd0, b[15:0]};
                is_byte = 1'b1;
            end
            ade_pkg::FN_SXTB:
            begin
                res_raw = {{24{b[7]}}, b[7:0]};
                is_byte = 1'b1;
            end
            ade_pkg::FN_SXTH:
            begin
                res_raw = {{16{b[15]}}, b[15:0]};
                is_byte = 1'b1;
            end
            default:
            begin
                is_dp = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rctl   = '0;
        result = '0;
        if (is_byte)
        begin
            // Reverse/extend: no condition, writes to PC are dropped.
            result         = res_raw;
            rctl.executed  = ~ctrl.dest_is_pc;
            rctl.reg_write = ~ctrl.dest_is_pc;
        end
        else if (is_dp && ctrl.cond_ok)
        begin
            result        = res_raw;
            rctl.executed = 1'b1;
            if (ctrl.func == ade_pkg::FN_TST
                || (logical && ctrl.set_flags && !ctrl.dest_is_pc))
            begin
                rctl.wr_nz = 1'b1;
                rctl.wr_c  = 1'b1;
                rctl.c_val = ctrl.shifter_carry;
            end
            if (flag_arith
                || (ctrl.func == ade_pkg::FN_RSB && ctrl.set_flags && !ctrl.dest_is_pc))
            begin
                rctl.wr_nz = 1'b1;
                rctl.wr_c  = 1'b1;
                rctl.c_val = add_c;
                rctl.wr_v  = 1'b1;
                rctl.v_val = add_v;
            end
            if (to_dest)
            begin
                rctl.reg_write  = ~ctrl.dest_is_pc;
                rctl.exc_return = ctrl.dest_is_pc & ctrl.set_flags & ~movwt;
                rctl.pc_write   = ctrl.dest_is_pc & ~(ctrl.set_flags & ~movwt);
            end
        end
    end

endmodule

[hdl/arm_data_processing_execute.sv]
// Top level of the three-stage ARM data-processing execute pipeline.
`timescale 1ns / 1ps

// Use of the block:
// - Slave channel s_axis_*: one pre-decoded instruction per item, func on tuser,
//   the operands, condition, S bit, flags and old Rd packed in tdata.
// - Master channel m_axis_*: one result item per instruction, in order: the
//   executed/destination indications, the 32-bit result and the new NZCV.
// - Pipeline: decode and condition check, then ALU and destination choice,
//   then flag update into the output register. An accepted item passes the
//   stage 1, stage 2 and stage 3 registers in order and is offered on m_axis
//   from the stage 3 register.
// - Throughput: one item per cycle when unstalled; a new item is taken while
//   older ones are in flight; slowest stage: 32-bit adder with result select.
// - Stall: each stage holds its item while the stage after it is full and
//   cannot move; ready ripples back stage by stage, so bubbles are filled and
//   nothing is dropped or repeated. s_axis_tready falls only when all three
//   stages hold items and m_axis_tready is low.
// - Reset: rst_n clears all stage valid bits; the block comes out empty and
//   ready, and holds no other state between items.
module arm_data_processing_execute (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata from bit 0: cond[3:0], set_flags, operand_a[31:0], operand_b[31:0],
    // shifter_carry, flags_in[3:0], dest_is_pc, dest_old[31:0], zero padding
    input  logic [ade_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: func[4:0]
    input  logic [ade_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata from bit 0: executed, reg_write, pc_write, exc_return,
    // result_value[31:0], flags_out[3:0]
    output logic [ade_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // Unpack the incoming item.
    logic [3:0]  in_cond;
    logic        in_set_flags;
    logic [31:0] in_a;
    logic [31:0] in_b;
    logic        in_shc;
    logic [3:0]  in_flags;
    logic        in_pc;
    logic [31:0] in_old;

    assign in_cond      = s_axis_tdata[3:0];
    assign in_set_flags = s_axis_tdata[4];
    assign in_a         = s_axis_tdata[36:5];
    assign in_b         = s_axis_tdata[68:37];
    assign in_shc       = s_axis_tdata[69];
    assign in_flags     = s_axis_tdata[73:70];
    assign in_pc        = s_axis_tdata[74];
    assign in_old       = s_axis_tdata[106:75];

    // Stage valid bits and ready chain.
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic ready1, ready2, ready3;

    assign ready3 = ~v3_reg | m_axis_tready;
    assign ready2 = ~v2_reg | ready3;
    assign ready1 = ~v1_reg | ready2;

    assign s_axis_tready = ready1;

    // Advance each stage when the next one can take its item.
    assign v1_next = ready1 ? s_axis_tvalid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;
    assign v3_next = ready3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ---------------- Stage 1: decode, condition check, adder operands
    ade_pkg::op_ctrl_t ctrl1_next, ctrl1_reg;
    logic [31:0] a1_reg, b1_reg, old1_reg;
    logic [3:0]  fl1_reg;
    logic [31:0] x1_next, y1_next, x1_reg, y1_reg;
    logic        cin1_next, cin1_reg;

    always_comb
    begin
        ctrl1_next.func          = ade_pkg::func_t'(s_axis_tuser);
        ctrl1_next.cond_ok       = ade_pkg::cond_pass(in_cond, in_flags);
        ctrl1_next.set_flags     = in_set_flags;
        ctrl1_next.shifter_carry = in_shc;
        ctrl1_next.dest_is_pc    = in_pc;
        // CMP: a - b, CMN: a + b, RSB: b - a.
        x1_next   = in_a;
        y1_next   = in_b;
        cin1_next = 1'b0;
        case (ade_pkg::func_t'(s_axis_tuser))
            ade_pkg::FN_CMP:
            begin
                y1_next   = ~in_b;
                cin1_next = 1'b1;
            end
            ade_pkg::FN_RSB:
            begin
                x1_next   = in_b;
                y1_next   = ~in_a;
                cin1_next = 1'b1;
            end
            default:
            begin
                cin1_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            ctrl1_reg <= ctrl1_next;
            a1_reg    <= in_a;
            b1_reg    <= in_b;
            old1_reg  <= in_old;
            fl1_reg   <= in_flags;
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            cin1_reg  <= cin1_next;
        end
    end

    // ---------------- Stage 2: ALU, result select, destination decision
    ade_pkg::res_ctrl_t rctl2_next, rctl2_reg;
    logic [31:0] res2_next, res2_reg;
    logic [3:0]  fl2_reg;

    ade_alu u_alu (
        .ctrl      (ctrl1_reg),
        .operand_a (a1_reg),
        .operand_b (b1_reg),
        .dest_old  (old1_reg),
        .add_x     (x1_reg),
        .add_y     (y1_reg),
        .add_cin   (cin1_reg),
        .rctl      (rctl2_next),
        .result    (res2_next)
    );

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            rctl2_reg <= rctl2_next;
            res2_reg  <= res2_next;
            fl2_reg   <= fl1_reg;
        end
    end

    // ---------------- Stage 3: flag update into the output register
    logic [3:0]  fl3_next, fl3_reg;
    logic [3:0]  ind3_reg;
    logic [31:0] res3_reg;

    always_comb
    begin
        fl3_next = fl2_reg;
        if (rctl2_reg.wr_nz)
        begin
            fl3_next[ade_pkg::FL_N] = res2_reg[31];
            fl3_next[ade_pkg::FL_Z] = (res2_reg == 32'd0);
        end
        if (rctl2_reg.wr_c)
        begin
            fl3_next[ade_pkg::FL_C] = rctl2_reg.c_val;
        end
        if (rctl2_reg.wr_v)
        begin
            fl3_next[ade_pkg::FL_V] = rctl2_reg.v_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            ind3_reg <= {rctl2_reg.exc_return, rctl2_reg.pc_write,
                         rctl2_reg.reg_write, rctl2_reg.executed};
            res3_reg <= res2_reg;
            fl3_reg  <= fl3_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {fl3_reg, res3_reg, ind3_reg};

`ifndef NO_ASSERTIONS
    // At most one destination is chosen for a result.
    a_one_dest: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[3:1]))
        else $error("more than one destination on an output item");

    // A result that did not execute writes nowhere.
    a_no_exec_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3:1] == 3'b000))
        else $error("write indicated for an item that did not execute");

    // An item in stage 1 that cannot move is still there next cycle.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !ready2) |=> v1_reg)
        else $error("stage 1 item lost under stall");

    // An item in stage 2 that cannot move is still there next cycle.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ready3) |=> (v2_reg && $stable(res2_reg)))
        else $error("stage 2 item lost or changed under stall");
`endif

endmodule

[bench/arm_data_processing_execute_tb.sv]
// Self-checking stream testbench for the ARM data-processing execute block.
`timescale 1ns / 1ps

module arm_data_processing_execute_tb;

    // Condition codes used by name in the directed part.
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    // Highest func code; everything above FN_SXTH is a no-op.
    localparam logic [4:0] FN_UNDEF_TOP = 5'd31;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1750;

    // One instruction as it travels on the slave side.
    typedef struct {
        logic [4:0]  func;
        logic [3:0]  cond;
        logic        set_flags;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic        shifter_carry;
        logic [3:0]  flags_in;
        logic        dest_is_pc;
        logic [31:0] dest_old;
    } instr_t;

    // What the execute stage should hand back for one instruction.
    typedef struct {
        logic        executed;
        logic        reg_write;
        logic        pc_write;
        logic        exc_return;
        logic [31:0] result_value;
        logic [3:0]  flags_out;
    } outcome_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ade_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [ade_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ade_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    outcome_t    pending_results[$];
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    int unsigned rx_cycle = 0;
    int          burst_left = 0;

    arm_data_processing_execute u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Evaluate the ARM condition field against NZCV; the top pair always passes.
    function automatic logic condition_holds(input logic [3:0] c, input logic [3:0] f);
        logic base;
        if (c[3:1] == ade_pkg::CP_ALWAYS)
        begin
            return 1'b1;
        end
        case (c[3:1])
            ade_pkg::CP_EQNE: base = f[ade_pkg::FL_Z];
            ade_pkg::CP_CSCC: base = f[ade_pkg::FL_C];
            ade_pkg::CP_MIPL: base = f[ade_pkg::FL_N];
            ade_pkg::CP_VSVC: base = f[ade_pkg::FL_V];
            ade_pkg::CP_HILS: base = f[ade_pkg::FL_C] & ~f[ade_pkg::FL_Z];
            ade_pkg::CP_GELT: base = (f[ade_pkg::FL_N] == f[ade_pkg::FL_V]);
            default: base = ~f[ade_pkg::FL_Z] & (f[ade_pkg::FL_N] == f[ade_pkg::FL_V]);
        endcase
        return c[0] ? ~base : base;
    endfunction

    function automatic outcome_t execute_instr(input instr_t it);
        outcome_t    o;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [32:0] sum;
        logic [3:0]  f;
        logic        logical;
        logic        to_dest;
        logic        movwt;
        a = it.operand_a;
        b = it.operand_b;
        f = it.flags_in;
        r = '0;
        logical = 1'b0;
        to_dest = 1'b1;
        movwt = 1'b0;
        o.executed = 1'b0;
        o.reg_write = 1'b0;
        o.pc_write = 1'b0;
        o.exc_return = 1'b0;
        o.result_value = '0;
        o.flags_out = f;
        if (it.func >= ade_pkg::FN_REV && it.func <= ade_pkg::FN_SXTH)
        begin
            // Byte reverse and extend: no condition, S ignored, PC write dropped.
            case (it.func)
                ade_pkg::FN_REV:   r = {b[7:0], b[15:8], b[23:16], b[31:24]};
                ade_pkg::FN_REV16: r = {b[23:16], b[31:24], b[7:0], b[15:8]};
                ade_pkg::FN_REVSH: r = {{16{b[7]}}, b[7:0], b[15:8]};
                ade_pkg::FN_UXTB:  r = {24'd0, b[7:0]};
                ade_pkg::FN_UXTH:  r = {16'd0, b[15:0]};
                ade_pkg::FN_SXTB:  r = {{24{b[7]}}, b[7:0]};
                default:           r = {{16{b[15]}}, b[15:0]};
            endcase
            o.result_value = r;
            if (!it.dest_is_pc)
            begin
                o.executed = 1'b1;
                o.reg_write = 1'b1;
            end
        end
        else if (it.func <= ade_pkg::FN_MOVT && condition_holds(it.cond, f))
        begin
            o.executed = 1'b1;
            case (it.func)
                ade_pkg::FN_AND:
                begin
                    r = a & b;
                    logical = 1'b1;
                end
                ade_pkg::FN_ORR:
                begin
                    r = a | b;
                    logical = 1'b1;
                end
                ade_pkg::FN_BIC:
                begin
                    r = a & ~b;
                    logical = 1'b1;
                end
                ade_pkg::FN_TST:
                begin
                    r = a & b;
                    to_dest = 1'b0;
                    f[ade_pkg::FL_N] = r[31];
                    f[ade_pkg::FL_Z] = (r == '0);
                    f[ade_pkg::FL_C] = it.shifter_carry;
                end
                ade_pkg::FN_CMP:
                begin
                    r = a - b;
                    to_dest = 1'b0;
                    f[ade_pkg::FL_N] = r[31];
                    f[ade_pkg::FL_Z] = (r == '0);
                    f[ade_pkg::FL_C] = (a >= b);
                    f[ade_pkg::FL_V] = (a[31] ^ b[31]) & (a[31] ^ r[31]);
                end
                ade_pkg::FN_CMN:
                begin
                    sum = {1'b0, a} + {1'b0, b};
                    r = sum[31:0];
                    to_dest = 1'b0;
                    f[ade_pkg::FL_N] = r[31];
                    f[ade_pkg::FL_Z] = (r == '0);
                    f[ade_pkg::FL_C] = sum[32];
                    f[ade_pkg::FL_V] = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
                end
                ade_pkg::FN_RSB:
                begin
                    r = b - a;
                    if (it.set_flags && !it.dest_is_pc)
                    begin
                        f[ade_pkg::FL_N] = r[31];
                        f[ade_pkg::FL_Z] = (r == '0);
                        f[ade_pkg::FL_C] = (b >= a);
                        f[ade_pkg::FL_V] = (b[31] ^ a[31]) & (b[31] ^ r[31]);
                    end
                end
                ade_pkg::FN_MOV:
                begin
                    r = b;
                    logical = 1'b1;
                end
                ade_pkg::FN_MVN:
                begin
                    r = ~b;
                    logical = 1'b1;
                end
                ade_pkg::FN_MOVW:
                begin
                    r = {16'd0, b[15:0]};
                    movwt = 1'b1;
                end
                default:
                begin
                    r = {b[15:0], it.dest_old[15:0]};
                    movwt = 1'b1;
                end
            endcase
            if (logical && it.set_flags && !it.dest_is_pc)
            begin
                f[ade_pkg::FL_N] = r[31];
                f[ade_pkg::FL_Z] = (r == '0);
                f[ade_pkg::FL_C] = it.shifter_carry;
            end
            if (to_dest)
            begin
                if (!it.dest_is_pc)
                begin
                    o.reg_write = 1'b1;
                end
                else if (it.set_flags && !movwt)
                begin
                    o.exc_return = 1'b1;
                end
                else
                begin
                    o.pc_write = 1'b1;
                end
            end
            o.result_value = r;
            o.flags_out = f;
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic instr_t make_instr(input logic [4:0] func, input logic [3:0] cond,
                                          input logic s, input logic [31:0] a,
                                          input logic [31:0] b, input logic shc,
                                          input logic [3:0] flags, input logic pc,
                                          input logic [31:0] old);
        instr_t it;
        it.func = func;
        it.cond = cond;
        it.set_flags = s;
        it.operand_a = a;
        it.operand_b = b;
        it.shifter_carry = shc;
        it.flags_in = flags;
        it.dest_is_pc = pc;
        it.dest_old = old;
        return it;
    endfunction

    // Bias operands towards the corners that move the flags.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        if ($urandom_range(0, 31) == 0)
        begin
            it.func = 5'($urandom_range(ade_pkg::FN_SXTH + 1, FN_UNDEF_TOP));
        end
        else
        begin
            it.func = 5'($urandom_range(ade_pkg::FN_AND, ade_pkg::FN_SXTH));
        end
        it.cond = 4'($urandom_range(0, 15));
        it.set_flags = 1'($urandom_range(0, 1));
        it.operand_a = pick_word();
        // Equal operands now and then, so compares hit zero and carry edges.
        it.operand_b = ($urandom_range(0, 7) == 0) ? it.operand_a : pick_word();
        it.shifter_carry = 1'($urandom_range(0, 1));
        it.flags_in = 4'($urandom_range(0, 15));
        it.dest_is_pc = ($urandom_range(0, 5) == 0);
        it.dest_old = $urandom;
        return it;
    endfunction

    // Offer one item, hold it until accepted, record its outcome, then
    // drop tvalid for a random gap once the current burst runs out.
    task automatic send_item(input instr_t it);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {5'd0, it.dest_old, it.dest_is_pc, it.flags_in, it.shifter_carry,
                          it.operand_b, it.operand_a, it.set_flags, it.cond};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        pending_results.push_back(execute_instr(it));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    task automatic test_logic_ops();
        send_item(make_instr(ade_pkg::FN_AND, COND_AL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b0, 4'b0001, 1'b0, 32'h0));
        // Zero result sets Z and keeps V.
        send_item(make_instr(ade_pkg::FN_ORR, COND_AL, 1'b1, 32'h0, 32'h0, 1'b1, 4'b1001,
                             1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_BIC, COND_AL, 1'b0, 32'hFFFF_FFFF, 32'h0000_FFFF,
                             1'b1, 4'b0000, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_MOV, COND_AL, 1'b1, 32'h0, 32'h8000_0000, 1'b0,
                             4'b0110, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_MVN, COND_AL, 1'b1, 32'h1234_5678, 32'hFFFF_FFFF,
                             1'b1, 4'b1000, 1'b0, 32'h0));
    endtask

    task automatic test_compare_ops();
        // TST writes flags with S clear.
        send_item(make_instr(ade_pkg::FN_TST, COND_AL, 1'b0, 32'h8000_0001, 32'hFFFF_FFFF,
                             1'b1, 4'b0000, 1'b0, 32'h0));
        // Borrow; destination PC must not produce a write.
        send_item(make_instr(ade_pkg::FN_CMP, COND_AL, 1'b1, 32'h0, 32'h1, 1'b0, 4'b0000,
                             1'b1, 32'h0));
        // Signed overflow on subtract.
        send_item(make_instr(ade_pkg::FN_CMP, COND_AL, 1'b0, 32'h8000_0000, 32'h1, 1'b0,
                             4'b0000, 1'b0, 32'h0));
        // Carry out and zero on add.
        send_item(make_instr(ade_pkg::FN_CMN, COND_AL, 1'b0, 32'hFFFF_FFFF, 32'h1, 1'b0,
                             4'b1001, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_RSB, COND_AL, 1'b1, 32'h1, 32'h0, 1'b0, 4'b0010,
                             1'b0, 32'h0));
    endtask

    task automatic test_wide_moves();
        send_item(make_instr(ade_pkg::FN_MOVW, COND_AL, 1'b1, 32'h0, 32'hABCD_FFFF, 1'b1,
                             4'b0101, 1'b0, 32'hFFFF_FFFF));
        send_item(make_instr(ade_pkg::FN_MOVT, COND_AL, 1'b0, 32'h0, 32'hFFFF_8001, 1'b0,
                             4'b1010, 1'b0, 32'hFFFF_FFFF));
    endtask

    // A failing condition must not stop these; REV to PC is dropped.
    task automatic test_reverse_extend();
        send_item(make_instr(ade_pkg::FN_REV, COND_EQ, 1'b1, 32'h0, 32'h1122_3380, 1'b1,
                             4'b0000, 1'b1, 32'h0));
        send_item(make_instr(ade_pkg::FN_REV16, COND_EQ, 1'b1, 32'h0, 32'h1122_3344, 1'b1,
                             4'b0000, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_REVSH, COND_EQ, 1'b0, 32'h0, 32'hFFFF_0080, 1'b0,
                             4'b0000, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_UXTB, COND_NE, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0,
                             4'b0100, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_UXTH, COND_NE, 1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0,
                             4'b0100, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_SXTB, COND_EQ, 1'b0, 32'h0, 32'h0000_0080, 1'b0,
                             4'b0000, 1'b0, 32'h0));
        send_item(make_instr(ade_pkg::FN_SXTH, COND_EQ, 1'b0, 32'h0, 32'h0000_8000, 1'b0,
                             4'b0000, 1'b0, 32'h0));
    endtask

    task automatic test_pc_destination();
        // S clear: plain branch.
        send_item(make_instr(ade_pkg::FN_MOV, COND_AL, 1'b0, 32'h0, 32'h0000_1001, 1'b1,
                             4'b0000, 1'b1, 32'h0));
        // S set: exception return, flags untouched.
        send_item(make_instr(ade_pkg::FN_ORR, COND_AL, 1'b1, 32'h8000_0000, 32'h0, 1'b1,
                             4'b0110, 1'b1, 32'h0));
        // MOVT to PC is a branch even with S set.
        send_item(make_instr(ade_pkg::FN_MOVT, COND_AL, 1'b1, 32'h0, 32'h0000_FFFF, 1'b0,
                             4'b0000, 1'b1, 32'h0000_0001));
    endtask

    task automatic test_conditions();
        // NE with Z set fails: result zero, flags passed through.
        send_item(make_instr(ade_pkg::FN_AND, COND_NE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, 4'b1111, 1'b0, 32'h0));
        // Code 15 behaves as always.
        send_item(make_instr(ade_pkg::FN_CMP, COND_NV, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             1'b0, 4'b1111, 1'b0, 32'h0));
        // Undefined operation is a no-op.
        send_item(make_instr(FN_UNDEF_TOP, COND_AL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, 4'b1111, 1'b1, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Let the pipeline run dry once in the middle of the stream.
            if (i == RANDOM_ITEMS / 2)
            begin
                wait_for_results();
            end
            send_item(random_instr());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: cycle through the stall patterns in turn, one window each
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_axis_tready <= (rx_cycle[2:0] > 3'd2);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Compare each accepted result with the oldest outstanding outcome.
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item %h", m_axis_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("executed", 32'(want.executed), 32'(m_axis_tdata[0]));
                check_field("reg_write", 32'(want.reg_write), 32'(m_axis_tdata[1]));
                check_field("pc_write", 32'(want.pc_write), 32'(m_axis_tdata[2]));
                check_field("exc_return", 32'(want.exc_return), 32'(m_axis_tdata[3]));
                check_field("result_value", want.result_value, m_axis_tdata[35:4]);
                check_field("flags_out", 32'(want.flags_out), 32'(m_axis_tdata[39:36]));
            end
        end
    end

    // Abort when neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_logic_ops();
        test_compare_ops();
        test_wide_moves();
        test_reverse_extend();
        test_pc_destination();
        test_conditions();
        wait_for_results();
        test_random_stream();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[arm_data_processing_execute.f]
hdl/ade_pkg.sv
hdl/ade_alu.sv
hdl/arm_data_processing_execute.sv
bench/arm_data_processing_execute_tb.sv
